/* rtl/mfrt_pkg.sv */
// shared types and constants of the fragment reassembly table
package mfrt_pkg;

  localparam int unsigned TIMEOUT_RESET = 32'd60000;

  typedef enum logic [2:0] {
    KIND_SINGLE    = 3'd0,
    KIND_STORED    = 3'd1,
    KIND_DUPLICATE = 3'd2,
    KIND_RANGE     = 3'd3,
    KIND_COMPLETE  = 3'd4,
    KIND_TIMEOUT   = 3'd5
  } kind_t;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_SWEEP   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic [15:0] ref_number;
    logic [63:0] sender_key;
    logic [7:0]  part_number;
    logic [7:0]  total_parts;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] out_ref_number;
    logic [63:0] out_sender_key;
    logic [15:0] part_mask;
    logic [7:0]  slot_total;
    logic [4:0]  received_count;
    logic        evicted;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic sweep_step;
    logic single;
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic is_sweep;
    logic is_single;
    logic sweep_last;
  } status_t;

endpackage

/* rtl/mfrt_ctrl.sv */
// controller state machine of the fragment reassembly table
module mfrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mfrt_pkg::status_t status,
  output mfrt_pkg::cmd_t    cmd
);

  mfrt_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfrt_pkg::ST_IDLE:   if (start) state_nxt = mfrt_pkg::ST_LOOKUP;
      mfrt_pkg::ST_LOOKUP: begin
        if (status.is_sweep) state_nxt = mfrt_pkg::ST_SWEEP;
        else if (status.is_single) state_nxt = mfrt_pkg::ST_DONE;
        else state_nxt = mfrt_pkg::ST_UPDATE;
      end
      mfrt_pkg::ST_UPDATE: state_nxt = mfrt_pkg::ST_DONE;
      mfrt_pkg::ST_SWEEP:  if (status.sweep_last) state_nxt = mfrt_pkg::ST_DONE;
      mfrt_pkg::ST_DONE:   state_nxt = mfrt_pkg::ST_IDLE;
      default:             state_nxt = mfrt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      mfrt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mfrt_pkg::ST_LOOKUP: begin
        cmd.lookup = ~status.is_sweep & ~status.is_single;
        cmd.single = status.is_single & ~status.is_sweep;
      end
      mfrt_pkg::ST_UPDATE: cmd.update = 1'b1;
      mfrt_pkg::ST_SWEEP:  cmd.sweep_step = 1'b1;
      mfrt_pkg::ST_DONE:   ;
      default:             ;
    endcase
  end

endmodule

/* rtl/mfrt_dp.sv */
// slot table, lookup, eviction search and sweep datapath
module mfrt_dp #(
  parameter int SLOTS = 8,
  parameter int PARTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfrt_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  mfrt_pkg::cmd_t      cmd,
  output mfrt_pkg::status_t   status,
  output logic                out_valid,
  output mfrt_pkg::out_word_t out_word
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(PARTS + 1);

  logic [31:0]    timeout_r;
  mfrt_pkg::in_word_t item_r;
  logic [SLOTS-1:0] busy_r;
  logic [15:0]    ref_r   [SLOTS];
  logic [63:0]    snd_r   [SLOTS];
  logic [7:0]     tot_r   [SLOTS];
  logic [CW-1:0]  rcv_r   [SLOTS];
  logic [31:0]    first_r [SLOTS];
  logic [PARTS-1:0] mask_r [SLOTS];
  logic [SW-1:0]  sel_r;
  logic           found_r, evict_r;
  logic [SW-1:0]  sweep_r;
  logic           out_valid_r;
  mfrt_pkg::out_word_t out_r;

  // lookup: match, lowest free, oldest
  logic [SW-1:0] match_idx, free_idx, old_idx;
  logic          match_any, free_any;
  logic [31:0]   best_age, age_i;
  always_comb begin
    match_idx = '0; free_idx = '0; old_idx = '0;
    match_any = 1'b0; free_any = 1'b0;
    best_age  = item_r.now_ms - first_r[0];
    age_i     = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (busy_r[i] && ref_r[i] == item_r.ref_number && snd_r[i] == item_r.sender_key) begin
        match_any = 1'b1; match_idx = SW'(i);
      end
      if (!busy_r[i]) begin
        free_any = 1'b1; free_idx = SW'(i);
      end
    end
    for (int i = 1; i < SLOTS; i++) begin
      age_i = item_r.now_ms - first_r[i];
      if (age_i > best_age) begin
        best_age = age_i; old_idx = SW'(i);
      end
    end
  end

  // part decode for the update step
  logic        in_range;
  logic [7:0]  pm1;
  logic [PARTS-1:0] bitv, cur_mask;
  logic [CW-1:0] cur_rcv;
  logic        dup;
  always_comb begin
    pm1      = item_r.part_number - 8'd1;
    in_range = 32'(pm1) < 32'(PARTS);
    bitv     = in_range ? (PARTS'(1) << pm1[$clog2(PARTS+1)-1:0]) : '0;
    cur_mask = found_r ? mask_r[sel_r] : '0;
    cur_rcv  = found_r ? rcv_r[sel_r] : '0;
    dup      = |(cur_mask & bitv);
  end

  // sweep scan: does any later slot expire
  logic exp_cur, exp_later;
  always_comb begin
    exp_cur   = busy_r[sweep_r] && (item_r.now_ms - first_r[sweep_r]) >= timeout_r;
    exp_later = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (SW'(i) > sweep_r && busy_r[i] && (item_r.now_ms - first_r[i]) >= timeout_r)
        exp_later = 1'b1;
    end
  end

  assign status.is_sweep   = item_r.opcode == mfrt_pkg::OP_SWEEP;
  assign status.is_single  = !(item_r.total_parts > 8'd1 && item_r.part_number != 8'd0);
  assign status.sweep_last = (32'(sweep_r) == 32'(SLOTS - 1)) || !exp_later;

  function automatic logic [15:0] mask16(input logic [PARTS-1:0] m);
    logic [63:0] w;
    w = 64'(m);
    return w[15:0];
  endfunction

  // control registers and table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= mfrt_pkg::TIMEOUT_RESET;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rcv_r[i] <= '0; first_r[i] <= '0; mask_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) timeout_r <= cfg_wdata;
      if (cmd.load) sweep_r <= '0;
      if (cmd.single) begin
        out_valid_r <= 1'b1;
        out_r <= '{kind: mfrt_pkg::KIND_SINGLE, slot: 3'd0,
                   out_ref_number: item_r.ref_number, out_sender_key: item_r.sender_key,
                   part_mask: 16'd0, slot_total: item_r.total_parts,
                   received_count: 5'd0, evicted: 1'b0, last: 1'b1};
      end
      if (cmd.lookup) begin
        found_r <= match_any;
        evict_r <= !match_any && !free_any;
        sel_r   <= match_any ? match_idx : (free_any ? free_idx : old_idx);
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
        out_r.slot           <= 3'(sel_r);
        out_r.out_ref_number <= item_r.ref_number;
        out_r.out_sender_key <= item_r.sender_key;
        out_r.slot_total     <= found_r ? tot_r[sel_r] : item_r.total_parts;
        out_r.evicted        <= evict_r;
        out_r.last           <= 1'b1;
        busy_r[sel_r]        <= 1'b1;
        if (!found_r) begin
          ref_r[sel_r]   <= item_r.ref_number;
          snd_r[sel_r]   <= item_r.sender_key;
          tot_r[sel_r]   <= item_r.total_parts;
          first_r[sel_r] <= item_r.now_ms;
        end
        if (!in_range) begin
          out_r.kind           <= mfrt_pkg::KIND_RANGE;
          out_r.part_mask      <= mask16(cur_mask);
          out_r.received_count <= 5'(cur_rcv);
          mask_r[sel_r] <= cur_mask;
          rcv_r[sel_r]  <= cur_rcv;
        end else begin
          out_r.part_mask      <= mask16(cur_mask | bitv);
          out_r.received_count <= 5'(cur_rcv + CW'(!dup));
          if (32'(cur_rcv + CW'(!dup)) >= 32'(item_r.total_parts)) begin
            out_r.kind    <= mfrt_pkg::KIND_COMPLETE;
            busy_r[sel_r] <= 1'b0;
            mask_r[sel_r] <= '0;
            rcv_r[sel_r]  <= '0;
          end else begin
            out_r.kind    <= dup ? mfrt_pkg::KIND_DUPLICATE : mfrt_pkg::KIND_STORED;
            mask_r[sel_r] <= cur_mask | bitv;
            rcv_r[sel_r]  <= cur_rcv + CW'(!dup);
          end
        end
      end
      if (cmd.sweep_step) begin
        if (exp_cur) begin
          out_valid_r <= 1'b1;
          out_r <= '{kind: mfrt_pkg::KIND_TIMEOUT, slot: 3'(sweep_r),
                     out_ref_number: ref_r[sweep_r], out_sender_key: snd_r[sweep_r],
                     part_mask: mask16(mask_r[sweep_r]), slot_total: tot_r[sweep_r],
                     received_count: 5'(rcv_r[sweep_r]), evicted: 1'b0,
                     last: status.sweep_last};
          busy_r[sweep_r] <= 1'b0;
          mask_r[sweep_r] <= '0;
          rcv_r[sweep_r]  <= '0;
        end
        if (32'(sweep_r) != 32'(SLOTS - 1)) sweep_r <= sweep_r + SW'(1);
      end
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* rtl/message_fragment_reassembly_table_core.sv */
// top level of the message fragment reassembly table
// Usage: drive in_word and raise start while busy is low; the word is taken
// at that edge. Results appear on out_word for one cycle with out_valid high;
// the receiver cannot stall and must take each one.
// A fragment gives one result after the slot lookup and then the table update
// state; busy stays high through the lookup, update and done states, so the
// block takes no new word before it is through with the last one. A single
// message skips the update step and registers its result in the lookup state.
// A sweep walks the slots one per cycle, comparing the age of the current
// slot, and gives one result per expired slot, the last one with last set.
// Busy stays high through the done state and the sweep, which stops after the
// last expiring slot. A sweep with nothing expired gives no result.
// cfg_we/cfg_wdata write timeout_ms at any edge; write only while idle.
// Reset (rst_n low, synchronous) empties all slots and sets the timeout to
// 60000 ms; no clearing pass is needed.
module message_fragment_reassembly_table_core #(
  parameter int SLOTS = 8,
  parameter int PARTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mfrt_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  output mfrt_pkg::out_word_t out_word
);

  mfrt_pkg::cmd_t    cmd;
  mfrt_pkg::status_t status;

  mfrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .status(status), .cmd(cmd)
  );

  mfrt_dp #(.SLOTS(SLOTS), .PARTS(PARTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .status(status),
    .out_valid(out_valid), .out_word(out_word)
  );

endmodule

/* rtl/mfrt_checker.sv */
// port level checks of the fragment reassembly table
module mfrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input mfrt_pkg::out_word_t out_word
);

  // a result only while an item is in work
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // accepted item makes block busy
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");

  // result kinds are meaningful
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.kind <= mfrt_pkg::KIND_TIMEOUT) else $error("bad kind");

  // busy drops only after the final result
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |=> busy) else $error("item ended early");

endmodule

bind message_fragment_reassembly_table_core mfrt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);

/* tb/message_fragment_reassembly_table_core_tb.sv */
// testbench of the fragment reassembly table: directed and random words checked against a predictor
module message_fragment_reassembly_table_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int PARTS = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = SLOTS + 8;

  // predicted table and the queue of result words still to come
  class reassembly_scoreboard;
    logic [31:0] timeout_ms;
    logic        busy_q [SLOTS];
    logic [15:0] ref_q [SLOTS];
    logic [63:0] sender_q [SLOTS];
    logic [7:0]  total_q [SLOTS];
    logic [4:0]  recv_q [SLOTS];
    logic [31:0] first_q [SLOTS];
    logic [15:0] mask_q [SLOTS];
    mfrt_pkg::out_word_t due_words [$];
    int          errors;

    function void clear_table();
      timeout_ms = mfrt_pkg::TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        busy_q[i] = 0; ref_q[i] = '0; sender_q[i] = '0; total_q[i] = '0;
        recv_q[i] = '0; first_q[i] = '0; mask_q[i] = '0;
      end
      due_words.delete();
      errors = 0;
    endfunction

    function mfrt_pkg::out_word_t slot_word(mfrt_pkg::kind_t k, int s, logic ev);
      mfrt_pkg::out_word_t o;
      o.kind = k; o.slot = s[2:0]; o.out_ref_number = ref_q[s];
      o.out_sender_key = sender_q[s]; o.part_mask = mask_q[s];
      o.slot_total = total_q[s]; o.received_count = recv_q[s];
      o.evicted = ev; o.last = 1'b1;
      return o;
    endfunction

    function void empty_slot(int s);
      busy_q[s] = 0; recv_q[s] = '0; mask_q[s] = '0;
    endfunction

    // work out the results of one accepted input word
    function void note_input(mfrt_pkg::in_word_t w);
      mfrt_pkg::out_word_t o;
      mfrt_pkg::out_word_t sweep_words [$];
      int          s;
      logic        found, ev;
      logic [31:0] best, age;
      mfrt_pkg::kind_t k;
      found = 0; ev = 0; s = 0;
      if (w.opcode == mfrt_pkg::OP_SWEEP) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (busy_q[i] && (w.now_ms - first_q[i]) >= timeout_ms) begin
            o = slot_word(mfrt_pkg::KIND_TIMEOUT, i, 1'b0);
            o.last = 1'b0;
            sweep_words.push_back(o);
            empty_slot(i);
          end
        end
        if (sweep_words.size() > 0) sweep_words[sweep_words.size()-1].last = 1'b1;
        foreach (sweep_words[j]) due_words.push_back(sweep_words[j]);
        return;
      end
      if (!(w.total_parts > 1 && w.part_number > 0)) begin
        o = '0;
        o.kind = mfrt_pkg::KIND_SINGLE; o.out_ref_number = w.ref_number;
        o.out_sender_key = w.sender_key; o.slot_total = w.total_parts; o.last = 1'b1;
        due_words.push_back(o);
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && busy_q[i] && ref_q[i] == w.ref_number && sender_q[i] == w.sender_key) begin
          s = i; found = 1;
        end
      end
      if (!found) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !busy_q[i]) begin
            s = i; found = 1;
          end
        end
        if (!found) begin
          // oldest first arrival goes, lowest index on a tie
          best = w.now_ms - first_q[0];
          s = 0;
          for (int i = 1; i < SLOTS; i++) begin
            age = w.now_ms - first_q[i];
            if (age > best) begin
              best = age; s = i;
            end
          end
          ev = 1;
        end
        busy_q[s] = 1; ref_q[s] = w.ref_number; sender_q[s] = w.sender_key;
        total_q[s] = w.total_parts; recv_q[s] = '0; first_q[s] = w.now_ms; mask_q[s] = '0;
      end
      if (w.part_number > PARTS) begin
        due_words.push_back(slot_word(mfrt_pkg::KIND_RANGE, s, ev));
        return;
      end
      if (mask_q[s][w.part_number-1]) begin
        k = mfrt_pkg::KIND_DUPLICATE;
      end else begin
        mask_q[s][w.part_number-1] = 1'b1;
        recv_q[s] = recv_q[s] + 5'd1;
        k = mfrt_pkg::KIND_STORED;
      end
      if ({3'b0, recv_q[s]} >= w.total_parts) begin
        due_words.push_back(slot_word(mfrt_pkg::KIND_COMPLETE, s, ev));
        empty_slot(s);
      end else begin
        due_words.push_back(slot_word(k, s, ev));
      end
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(mfrt_pkg::out_word_t got);
      mfrt_pkg::out_word_t e;
      if (due_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d slot %0d", got.kind, got.slot);
        errors++;
        return;
      end
      e = due_words.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.out_ref_number !== e.out_ref_number) begin
        $error("out_ref_number exp %h got %h", e.out_ref_number, got.out_ref_number); errors++;
      end
      if (got.out_sender_key !== e.out_sender_key) begin
        $error("out_sender_key exp %h got %h", e.out_sender_key, got.out_sender_key); errors++;
      end
      if (got.part_mask !== e.part_mask) begin
        $error("part_mask exp %h got %h", e.part_mask, got.part_mask); errors++;
      end
      if (got.slot_total !== e.slot_total) begin
        $error("slot_total exp %0d got %0d", e.slot_total, got.slot_total); errors++;
      end
      if (got.received_count !== e.received_count) begin
        $error("received_count exp %0d got %0d", e.received_count, got.received_count); errors++;
      end
      if (got.evicted !== e.evicted) begin
        $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  mfrt_pkg::in_word_t  in_word;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        out_valid;
  mfrt_pkg::out_word_t out_word;

  reassembly_scoreboard sb;
  int          idle_cycles;
  logic [31:0] now_ms;
  logic [15:0] ref_pool [12];
  logic [63:0] sender_pool [12];

  message_fragment_reassembly_table_core #(.SLOTS(SLOTS), .PARTS(PARTS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid), .out_word(out_word)
  );

  // clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // monitor of accepted input and result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_word);
      if (out_valid) sb.check_result(out_word);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // offer one word after a random gap and wait for it to be taken
  task automatic send_word(mfrt_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait for the block to fall idle, then write the timeout
  task automatic write_timeout(logic [31:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() > 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.timeout_ms = v;
  endtask

  function automatic mfrt_pkg::in_word_t frag_word(logic [31:0] t, logic [15:0] r,
                                                   logic [63:0] k, logic [7:0] p,
                                                   logic [7:0] n);
    mfrt_pkg::in_word_t w;
    w.opcode = mfrt_pkg::OP_ARRIVAL; w.now_ms = t; w.ref_number = r; w.sender_key = k;
    w.part_number = p; w.total_parts = n;
    return w;
  endfunction

  function automatic mfrt_pkg::in_word_t sweep_word(logic [31:0] t);
    mfrt_pkg::in_word_t w;
    w = '0;
    w.opcode = mfrt_pkg::OP_SWEEP; w.now_ms = t;
    w.ref_number = 16'($urandom()); w.sender_key = {$urandom(), $urandom()};
    w.part_number = 8'($urandom()); w.total_parts = 8'($urandom());
    return w;
  endfunction

  // random word: mostly fragments of a few pooled messages
  function automatic mfrt_pkg::in_word_t random_word();
    int sel, m;
    logic [7:0] n, p;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 4000);
    if (sel < 12) return sweep_word(now_ms);
    if (sel < 20) begin
      return frag_word(now_ms, 16'($urandom()), {$urandom(), $urandom()},
                       ($urandom_range(0, 1) ? 8'd0 : 8'($urandom())),
                       ($urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom())));
    end
    m = $urandom_range(0, 11);
    if (sel < 90) begin
      n = 8'($urandom_range(2, 6));
      p = 8'($urandom_range(1, n));
    end else begin
      n = 8'($urandom_range(2, 255));
      p = 8'($urandom_range(1, 255));
    end
    return frag_word(now_ms, ref_pool[m], sender_pool[m], p, n);
  endfunction

  initial begin
    sb = new();
    sb.clear_table();
    idle_cycles = 0;
    rst_n = 1'b0; start = 1'b0; in_word = '0; cfg_we = 1'b0; cfg_wdata = '0;
    now_ms = 32'd1000;
    for (int i = 0; i < 12; i++) begin
      ref_pool[i] = 16'($urandom());
      sender_pool[i] = {$urandom(), $urandom()};
    end
    ref_pool[0] = 16'h0000; sender_pool[0] = 64'h0;
    ref_pool[1] = 16'hFFFF; sender_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    ref_pool[2] = ref_pool[3];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: singles at the field extremes
    send_word(frag_word(32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'd1));
    send_word(frag_word(32'h0, 16'h0, 64'h0, 8'd0, 8'd255));
    send_word(frag_word(32'd5, 16'd7, 64'd9, 8'd3, 8'd0));
    // nothing busy yet: sweep without results
    send_word(sweep_word(32'd10));
    // fill all slots at one time, then a ninth message evicts on a tie
    for (int i = 0; i < SLOTS; i++)
      send_word(frag_word(32'd100, ref_pool[i], sender_pool[i], 8'd1, 8'd3));
    send_word(frag_word(32'd100, 16'h1234, 64'h0123_4567_89AB_CDEF, 8'd1, 8'd2));
    // duplicate, out of range, completion, and an eviction by age
    send_word(frag_word(32'd200, ref_pool[1], sender_pool[1], 8'd1, 8'd3));
    send_word(frag_word(32'd200, ref_pool[1], sender_pool[1], 8'd200, 8'd3));
    send_word(frag_word(32'd201, ref_pool[1], sender_pool[1], 8'd16, 8'd3));
    send_word(frag_word(32'd202, ref_pool[1], sender_pool[1], 8'd2, 8'd3));
    send_word(frag_word(32'd300, 16'h0042, 64'h5, 8'd17, 8'd255));
    send_word(frag_word(32'd301, 16'h0043, 64'h6, 8'd4, 8'd4));
    // sweep with the default timeout: oldest expire
    send_word(sweep_word(32'd60100));
    send_word(sweep_word(32'd70000));

    // random phases across timeout settings
    begin
      logic [31:0] setting [5];
      setting[0] = 32'd1; setting[1] = 32'd0; setting[2] = 32'hFFFF_FFFF;
      setting[3] = 32'd5000; setting[4] = $urandom();
      for (int ph = 0; ph < 5; ph++) begin
        write_timeout(setting[ph]);
        for (int j = 0; j < 66; j++) send_word(random_word());
      end
    end
    write_timeout(mfrt_pkg::TIMEOUT_RESET);
    for (int j = 0; j < 20; j++) send_word(random_word());

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
